/* src/gbc_pkg.sv */
package gbc_pkg;

  // register file contents as seen by the datapath
  typedef struct packed {
    logic        [15:0] calib_samples;
    logic        [14:0] still_limit;
    logic        [14:0] accel_limit;
    logic signed [15:0] def_bias_x;
    logic signed [15:0] def_bias_y;
    logic signed [15:0] def_bias_z;
  } cfg_t;

  // divider control from the sequencer
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int unsigned SENSOR_W  = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CORRECT_W = 17;

endpackage

/* src/gbc_if.sv */
// sample channel: one accelerometer and gyro reading per item
interface gbc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

// result channel: conditioned sample and mode
interface gbc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] clamped_x;
  logic signed [15:0] clamped_y;
  logic signed [15:0] clamped_z;
  logic signed [16:0] corrected_x;
  logic signed [16:0] corrected_y;
  logic signed [16:0] corrected_z;
  logic               mode;

  modport source (
    output valid, clamped_x, clamped_y, clamped_z,
    output corrected_x, corrected_y, corrected_z, mode,
    input  ready
  );
  modport sink (
    input  valid, clamped_x, clamped_y, clamped_z,
    input  corrected_x, corrected_y, corrected_z, mode,
    output ready
  );
endinterface

/* src/gbc_regs.sv */
module gbc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gbc_pkg::cfg_t       cfg
);

  typedef enum logic [2:0] {
    R_CALIB_SAMPLES = 3'd0,
    R_STILL_LIMIT   = 3'd1,
    R_ACCEL_LIMIT   = 3'd2,
    R_DEF_BIAS_X    = 3'd3,
    R_DEF_BIAS_Y    = 3'd4,
    R_DEF_BIAS_Z    = 3'd5
  } reg_idx_t;

  localparam logic [15:0] CALIB_RESET = 16'd1000;
  localparam logic [14:0] STILL_RESET = 15'd100;
  localparam logic [14:0] ACCEL_RESET = 15'd32767;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calib_samples <= CALIB_RESET;
      cfg.still_limit   <= STILL_RESET;
      cfg.accel_limit   <= ACCEL_RESET;
      cfg.def_bias_x    <= '0;
      cfg.def_bias_y    <= '0;
      cfg.def_bias_z    <= '0;
    end else if (wr) begin
      unique case (idx)
        R_CALIB_SAMPLES: cfg.calib_samples <= pwdata[15:0];
        R_STILL_LIMIT:   cfg.still_limit   <= pwdata[14:0];
        R_ACCEL_LIMIT:   cfg.accel_limit   <= pwdata[14:0];
        R_DEF_BIAS_X:    cfg.def_bias_x    <= pwdata[15:0];
        R_DEF_BIAS_Y:    cfg.def_bias_y    <= pwdata[15:0];
        R_DEF_BIAS_Z:    cfg.def_bias_z    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      R_CALIB_SAMPLES: prdata = {16'd0, cfg.calib_samples};
      R_STILL_LIMIT:   prdata = {17'd0, cfg.still_limit};
      R_ACCEL_LIMIT:   prdata = {17'd0, cfg.accel_limit};
      R_DEF_BIAS_X:    prdata = 32'(cfg.def_bias_x);
      R_DEF_BIAS_Y:    prdata = 32'(cfg.def_bias_y);
      R_DEF_BIAS_Z:    prdata = 32'(cfg.def_bias_z);
      default:         prdata = '0;
    endcase
  end

endmodule

/* src/gbc_div.sv */
module gbc_div #(
  parameter int unsigned DW = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gbc_pkg::div_ctrl_t     ctrl,
  input  logic signed [DW-1:0]   dividend [3],
  input  logic [15:0]            divisor,
  output logic signed [DW:0]     quotient [3],
  output gbc_pkg::div_stat_t     status
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [15:0]   rem [3];
  logic [DW-1:0] dq  [3];
  logic          neg [3];
  logic [16:0]   rem_sh [3];
  logic          ge  [3];

  // one quotient bit per lane and cycle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i], dq[i][DW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, divisor};
    end
  end

  // shared step counter and lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
      cnt         <= '0;
    end else begin
      status.done <= 1'b0;
      if (ctrl.start && !status.busy) begin
        status.busy <= 1'b1;
        cnt         <= CW'(DW);
        for (int i = 0; i < 3; i++) begin
          neg[i] <= dividend[i][DW-1];
          dq[i]  <= dividend[i][DW-1] ? DW'(-dividend[i]) : DW'(dividend[i]);
          rem[i] <= '0;
        end
      end else if (status.busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          for (int i = 0; i < 3; i++) begin
            dq[i]  <= {dq[i][DW-2:0], ge[i]};
            rem[i] <= ge[i] ? 16'(rem_sh[i] - {1'b0, divisor}) : rem_sh[i][15:0];
          end
        end else begin
          // restore the sign: truncation toward zero
          status.busy <= 1'b0;
          status.done <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            quotient[i] <= neg[i] ? -$signed({1'b0, dq[i]}) : $signed({1'b0, dq[i]});
          end
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start && !status.busy |=> status.busy && cnt == CW'(DW))
    else $error("divider did not load on start");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    status.busy && cnt == '0 |=> status.done && !status.busy)
    else $error("divider did not finish after the last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    status.done |-> !status.busy && $past(status.busy))
    else $error("divider done without a preceding run");

endmodule

/* src/gyro_bias_calibrate_condition_top.sv */
// Gyro zero-rate bias calibration and sample conditioning.
// The sample channel takes one accelerometer and gyro reading per item; the
// result channel returns the clamped accelerations, the bias-corrected rates
// and the mode (0 calibrating, 1 working) after that item. Both channels are
// valid/ready; the APB-style port sets the sample number, the stationary and
// clamp limits and the default biases; the user is to write it only while
// the block idles, as the block itself does not enforce this. An item that
// does not update the bias passes the states EVAL, ROUND and EMIT; a
// stationary calibration sample also passes DIVIDE and FINISH, where the
// three-lane bit-serial divider forms the running-mean step, one quotient
// bit per cycle. One item is processed at a time; a new item is taken as
// soon as the previous result sits in the output register, even while it
// waits there. A stalled receiver holds the result, and a finished item
// then waits to be loaded, so the sample channel stops after one item.
// Reset clears the mode to calibrating, the sample count and the biases,
// and restores the register defaults.
module gyro_bias_calibrate_condition_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  gbc_sample_if.sink          sample,
  gbc_result_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned BW = 16 + FRAC_BITS;
  localparam int unsigned DW = BW + 1;
  localparam logic signed [BW:0] HALF = (BW + 1)'((1 << FRAC_BITS) >> 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIVIDE,
    S_FINISH,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t                    state;
  gbc_pkg::cfg_t             cfg;
  gbc_pkg::div_ctrl_t        div_ctrl;
  gbc_pkg::div_stat_t        div_stat;

  logic                      working;
  logic [15:0]               accepted_count;
  logic signed [BW-1:0]      bias     [3];
  logic signed [DW-1:0]      diff     [3];
  logic signed [DW:0]        quot     [3];
  logic signed [16:0]        rnd      [3];
  logic signed [15:0]        acc_q    [3];
  logic signed [15:0]        rate_q   [3];
  logic signed [15:0]        def_c    [3];
  logic signed [15:0]        in_acc   [3];
  logic signed [15:0]        in_rate  [3];

  logic                      still;
  logic signed [DW-1:0]      diff_c   [3];
  logic signed [BW:0]        rnd_sum  [3];
  logic signed [17:0]        corr_w   [3];
  logic signed [16:0]        corr_c   [3];
  logic signed [15:0]        clamp_c  [3];
  logic signed [16:0]        acc_w    [3];
  logic signed [16:0]        rate_w   [3];
  logic signed [16:0]        still_lim;
  logic signed [16:0]        acc_lim;

  logic                      res_valid;
  logic signed [15:0]        res_clamp [3];
  logic signed [16:0]        res_corr  [3];
  logic                      res_mode;

  gbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gbc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (diff),
    .divisor  (accepted_count + 16'd1),
    .quotient (quot),
    .status   (div_stat)
  );

  // channel wiring
  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.clamped_x   = res_clamp[0];
  assign result.clamped_y   = res_clamp[1];
  assign result.clamped_z   = res_clamp[2];
  assign result.corrected_x = res_corr[0];
  assign result.corrected_y = res_corr[1];
  assign result.corrected_z = res_corr[2];
  assign result.mode        = res_mode;

  always_comb begin
    in_acc[0]  = sample.accel_x;
    in_acc[1]  = sample.accel_y;
    in_acc[2]  = sample.accel_z;
    in_rate[0] = sample.rate_x;
    in_rate[1] = sample.rate_y;
    in_rate[2] = sample.rate_z;
    def_c[0]   = cfg.def_bias_x;
    def_c[1]   = cfg.def_bias_y;
    def_c[2]   = cfg.def_bias_z;
  end

  // stationary test, mean step dividend, rounding and output forming
  always_comb begin
    still_lim = $signed({2'b00, cfg.still_limit});
    acc_lim   = $signed({2'b00, cfg.accel_limit});
    still     = 1'b1;
    for (int i = 0; i < 3; i++) begin
      rate_w[i] = 17'(rate_q[i]);
      acc_w[i]  = 17'(acc_q[i]);
      if (rate_w[i] > still_lim || rate_w[i] < -still_lim) begin
        still = 1'b0;
      end
      diff_c[i]  = (DW'(rate_q[i]) <<< FRAC_BITS) - DW'(bias[i]);
      rnd_sum[i] = (BW + 1)'(bias[i]) + HALF;
      corr_w[i]  = 18'(rate_q[i]) - 18'(rnd[i]);
      if (corr_w[i] > 18'sd65535) begin
        corr_c[i] = 17'sd65535;
      end else if (corr_w[i] < -18'sd65535) begin
        corr_c[i] = -17'sd65535;
      end else begin
        corr_c[i] = corr_w[i][16:0];
      end
      if (acc_w[i] > acc_lim) begin
        clamp_c[i] = acc_lim[15:0];
      end else if (acc_w[i] < -acc_lim) begin
        clamp_c[i] = 16'(-acc_lim);
      end else begin
        clamp_c[i] = acc_q[i];
      end
    end
  end

  // sequencer, calibration state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      working        <= 1'b0;
      accepted_count <= '0;
      div_ctrl.start <= 1'b0;
      res_valid      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bias[i] <= '0;
      end
    end else begin
      if (result.ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            for (int i = 0; i < 3; i++) begin
              acc_q[i]  <= in_acc[i];
              rate_q[i] <= in_rate[i];
            end
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!working) begin
            if (cfg.calib_samples == '0) begin
              for (int i = 0; i < 3; i++) begin
                bias[i] <= BW'(def_c[i]) <<< FRAC_BITS;
              end
              working <= 1'b1;
              state   <= S_ROUND;
            end else if (accepted_count < cfg.calib_samples) begin
              if (still) begin
                for (int i = 0; i < 3; i++) begin
                  diff[i] <= diff_c[i];
                end
                div_ctrl.start <= 1'b1;
                state          <= S_DIVIDE;
              end else begin
                state <= S_ROUND;
              end
            end else begin
              working <= 1'b1;
              state   <= S_ROUND;
            end
          end else begin
            state <= S_ROUND;
          end
        end
        S_DIVIDE: begin
          div_ctrl.start <= 1'b0;
          if (div_stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          for (int i = 0; i < 3; i++) begin
            bias[i] <= bias[i] + BW'(quot[i]);
          end
          accepted_count <= accepted_count + 16'd1;
          state          <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 3; i++) begin
            rnd[i] <= rnd_sum[i][BW:FRAC_BITS];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            for (int i = 0; i < 3; i++) begin
              res_clamp[i] <= clamp_c[i];
              res_corr[i]  <= corr_c[i];
            end
            res_mode  <= working;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_working_sticks: assert property (@(posedge clk) disable iff (rst)
    working |=> working)
    else $error("mode returned to calibrating");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> accepted_count == $past(accepted_count)
          || accepted_count == $past(accepted_count) + 16'd1)
    else $error("sample count jumped");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIVIDE)
    else $error("divider finished outside the divide phase");

endmodule
